[hdl/sha1he_pkg.sv]
// Shared types and constants of the SHA-1 hash engine.
`default_nettype none

package sha1he_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // Word 0 is the most significant digest word.
    localparam logic [4:0][31:0] INIT_CHAIN = '{H4, H3, H2, H1, H0};

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_message;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        STEP_MARK,
        STEP_ZERO,
        STEP_LEN
    } pad_step_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_EMIT
    } ret_t;

endpackage

`default_nettype wire

[hdl/sha1he_front.sv]
// Input side: accepts words, drops empty ones and queues the rest for the back end.
`default_nettype none

module sha1he_front #(
    parameter int QUEUE_DEPTH = sha1he_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tuser,   // [0] byte_present
    input  wire logic              s_axis_tlast,   // end_message
    output logic                   q_valid,
    output sha1he_pkg::item_t      q_item,
    input  wire logic              q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sha1he_pkg::item_t queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;
    sha1he_pkg::item_t in_item;

    assign s_axis_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign in_item       = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                             end_message: s_axis_tlast};
    // Drop words that carry neither a byte nor an end mark.
    assign push    = s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast);
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[hdl/sha1he_back.sv]
// Back end: block assembly, padding, 80-round compression and digest output.
`default_nettype none

module sha1he_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire sha1he_pkg::item_t q_item,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]             m_axis_tuser,   // [2:0] word_number
    output logic                   m_axis_tlast    // last_word
);

    sha1he_pkg::back_state_t state_reg, state_next;
    sha1he_pkg::pad_step_t   step_reg, step_next;
    sha1he_pkg::ret_t        ret_reg, ret_next, ret_sel;

    // Block buffer and message schedule share one 16-word shift line; word 0 is on top.
    logic [511:0]      window_reg, window_next;
    logic [4:0][31:0]  chain_reg, chain_next;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       a_next, b_next, c_next, d_next, e_next;
    logic [6:0]        round_reg, round_next;
    logic [5:0]        pos_reg, pos_next;
    logic [60:0]       total_reg, total_next;
    logic [63:0]       len_reg, len_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic [2:0]        m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    logic              shift_en;
    logic [7:0]        shift_byte;
    logic [31:0]       w_cur, w_new, f_val, k_val, t_val, sched_x;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // Round datapath
    assign w_cur   = window_reg[511:480];
    assign sched_x = window_reg[95:64] ^ window_reg[255:224] ^ window_reg[447:416] ^ w_cur;
    assign w_new   = {sched_x[30:0], sched_x[31]};

    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1he_pkg::K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1he_pkg::K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1he_pkg::K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1he_pkg::K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        ret_next     = ret_reg;
        ret_sel      = sha1he_pkg::RET_IDLE;
        window_next  = window_reg;
        chain_next   = chain_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        round_next   = round_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        len_next     = len_reg;
        out_idx_next = out_idx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        shift_en     = 1'b0;
        shift_byte   = '0;
        q_pop        = 1'b0;

        case (state_reg)
            sha1he_pkg::ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    if (q_item.end_message) begin
                        state_next = sha1he_pkg::ST_PAD;
                        step_next  = sha1he_pkg::STEP_MARK;
                        ret_sel    = sha1he_pkg::RET_PAD;
                    end
                    if (q_item.byte_present) begin
                        shift_en   = 1'b1;
                        shift_byte = q_item.data_byte;
                        total_next = total_reg + 1'b1;
                    end
                end
            end
            sha1he_pkg::ST_PAD: begin
                shift_en = 1'b1;
                case (step_reg)
                    sha1he_pkg::STEP_MARK: begin
                        shift_byte = sha1he_pkg::PAD_MARK;
                        len_next   = {total_reg, 3'b000};
                        step_next  = sha1he_pkg::STEP_ZERO;
                        ret_sel    = sha1he_pkg::RET_PAD;
                    end
                    sha1he_pkg::STEP_ZERO: begin
                        if (pos_reg == sha1he_pkg::LEN_POS) begin
                            shift_byte = len_reg[63:56];
                            len_next   = {len_reg[55:0], 8'h00};
                            step_next  = sha1he_pkg::STEP_LEN;
                            ret_sel    = sha1he_pkg::RET_EMIT;
                        end else begin
                            shift_byte = 8'h00;
                            ret_sel    = sha1he_pkg::RET_PAD;
                        end
                    end
                    sha1he_pkg::STEP_LEN: begin
                        shift_byte = len_reg[63:56];
                        len_next   = {len_reg[55:0], 8'h00};
                        ret_sel    = sha1he_pkg::RET_EMIT;
                    end
                    default: begin
                        shift_en  = 1'b0;
                        step_next = sha1he_pkg::STEP_ZERO;
                    end
                endcase
            end
            sha1he_pkg::ST_ROUND: begin
                window_next = {window_reg[479:0], w_new};
                a_next      = t_val;
                b_next      = a_reg;
                c_next      = {b_reg[1:0], b_reg[31:2]};
                d_next      = c_reg;
                e_next      = d_reg;
                round_next  = round_reg + 1'b1;
                if (round_reg == sha1he_pkg::LAST_ROUND) begin
                    state_next = sha1he_pkg::ST_ADD;
                end
            end
            sha1he_pkg::ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                case (ret_reg)
                    sha1he_pkg::RET_PAD:  state_next = sha1he_pkg::ST_PAD;
                    sha1he_pkg::RET_EMIT: begin
                        state_next   = sha1he_pkg::ST_EMIT;
                        out_idx_next = '0;
                    end
                    default:              state_next = sha1he_pkg::ST_IDLE;
                endcase
            end
            sha1he_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = chain_reg[out_idx_reg];
                    m_user_next  = out_idx_reg;
                    m_last_next  = (out_idx_reg == sha1he_pkg::LAST_WORD_IDX);
                    if (out_idx_reg == sha1he_pkg::LAST_WORD_IDX) begin
                        // Restore the chaining values for the next message.
                        chain_next   = sha1he_pkg::INIT_CHAIN;
                        total_next   = '0;
                        out_idx_next = '0;
                        state_next   = sha1he_pkg::ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = sha1he_pkg::ST_IDLE;
            end
        endcase

        // Shift one byte into the block; a full block starts the rounds.
        if (shift_en) begin
            window_next = {window_reg[503:0], shift_byte};
            pos_next    = pos_reg + 1'b1;
            if (pos_reg == sha1he_pkg::LAST_POS) begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                round_next = '0;
                ret_next   = ret_sel;
                state_next = sha1he_pkg::ST_ROUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha1he_pkg::ST_IDLE;
            step_reg    <= sha1he_pkg::STEP_MARK;
            ret_reg     <= sha1he_pkg::RET_IDLE;
            chain_reg   <= sha1he_pkg::INIT_CHAIN;
            round_reg   <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            ret_reg     <= ret_next;
            chain_reg   <= chain_next;
            round_reg   <= round_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            out_idx_reg <= out_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

[hdl/sha1_hash_engine.sv]
// SHA-1 hash engine top level: input queue plus compression back end.
//
// Feed a message one byte per word (tuser high marks a byte in tdata); a word with
// tlast high ends the message after its byte, if any, and the engine returns the
// five 32-bit digest words, most significant first, with the word number in tuser
// and tlast on the fifth. Words with neither flag are dropped. Input words pass
// through a QUEUE_DEPTH-entry queue, so the input keeps accepting while the back
// end is busy until the queue fills. The back end takes one message byte per cycle
// while it is idle; every 64th byte starts the compression rounds and one chaining
// add, all on a single round unit, and no byte is taken until they are done.
// Ending a message shifts in the pad and length one byte per cycle, one byte for
// each position left in the block (up to 64 bytes). When fewer than nine bytes
// are left, the pad spills over: the mark and zeros fill the block and an extra
// compression come first, then a full block of zeros and length. The engine then
// runs the last compression and presents one digest word per cycle while the
// result side is ready.
`default_nettype none

module sha1_hash_engine #(
    parameter int QUEUE_DEPTH = sha1he_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // end_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_number
    output logic             m_axis_tlast    // last_word
);

    logic              q_valid;
    logic              q_pop;
    sha1he_pkg::item_t q_item;

    sha1he_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    sha1he_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the SHA-1 hash engine: stream stimulus, digest predictor, checker.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_WORDS = 330;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] byte_present
    logic        s_axis_tlast = 1'b0;    // end_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_number
    logic        m_axis_tlast;           // last_word

    // Predictor state
    logic [31:0]  chain_h [5];
    logic [7:0]   block_buf [64];
    logic [60:0]  msg_bytes;
    digest_word_t expected_digest [$];
    digest_word_t want;

    int mismatch_count = 0;
    int in_max_gap = 6;
    int out_max_gap = 6;
    int ready_hold = 0;

    sha1_hash_engine DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain_h[0] = IV0;
        chain_h[1] = IV1;
        chain_h[2] = IV2;
        chain_h[3] = IV3;
        chain_h[4] = IV4;
        msg_bytes = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int j;
        for (j = 0; j < 16; j++) begin
            w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (j = 0; j < 80; j++) begin
            // 16-word rolling schedule
            if (j >= 16) begin
                w[j % 16] = rol(w[(j - 3) % 16] ^ w[(j - 8) % 16] ^ w[(j - 14) % 16]
                                ^ w[j % 16], 1);
            end
            if (j < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (j < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (j < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[j % 16];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Absorb one accepted word; on end of message, pad, finish and queue the digest.
    function automatic void sha1_absorb(input logic [7:0] data, input logic has_byte,
                                        input logic ends);
        int pos;
        int i;
        logic [63:0] bit_len;
        digest_word_t dw;
        if (has_byte) begin
            pos = int'(msg_bytes[5:0]);
            block_buf[pos] = data;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 63) compress_block();
        end
        if (!ends) return;
        pos = int'(msg_bytes[5:0]);
        block_buf[pos] = 8'h80;
        pos = pos + 1;
        // no room for the length: spill into an extra block
        if (pos > 56) begin
            while (pos < 64) begin
                block_buf[pos] = 8'h00;
                pos = pos + 1;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            block_buf[pos] = 8'h00;
            pos = pos + 1;
        end
        bit_len = {msg_bytes, 3'b000};
        for (i = 0; i < 8; i++) block_buf[56 + i] = bit_len[8*(7-i) +: 8];
        compress_block();
        for (i = 0; i < 5; i++) begin
            dw.word = chain_h[i];
            dw.index = i[2:0];
            dw.is_last = (i == 4);
            expected_digest = {expected_digest, dw};
        end
        restart_chain();
    endfunction

    // Result side: check each word, then draw the stall before the next one.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_digest.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, actual %h/%0d/%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_digest.pop_front();
                if (m_axis_tdata !== want.word) begin
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, want.word, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.index) begin
                    $display("%0t: word_number mismatch: expected %0d, actual %0d",
                             $time, want.index, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.is_last) begin
                    $display("%0t: last_word mismatch: expected %b, actual %b",
                             $time, want.is_last, m_axis_tlast);
                    mismatch_count++;
                end
            end
            ready_hold = $urandom_range(0, out_max_gap);
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [7:0] data, input logic has_byte, input logic ends);
        int gap;
        gap = $urandom_range(0, in_max_gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= has_byte;
        s_axis_tlast <= ends;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sha1_absorb(data, has_byte, ends);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_digests();
        drop_valid();
        while (expected_digest.size() != 0) @(posedge aclk);
    endtask

    // Random message of len bytes; the last byte rides on the end word half the time.
    task automatic send_message(input int len, inout int word_count);
        logic tail_byte;
        int i;
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len - tail_byte; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                word_count++;
            end
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            word_count++;
        end
        push_word(8'($urandom_range(0, 255)), tail_byte, 1'b1);
        word_count++;
    endtask

    task automatic test_empty_message();
        push_word(8'h00, 1'b0, 1'b1);
        // data present on the bus but not flagged as a byte
        push_word(8'hC3, 1'b0, 1'b1);
    endtask

    task automatic test_idle_and_extremes();
        push_word(8'h5A, 1'b0, 1'b0);
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hA5, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_abc();
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'h63, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int word_count;
        int len;
        logic paused;
        word_count = 0;
        paused = 1'b0;
        // one multi-block message first
        send_message($urandom_range(120, 130), word_count);
        while (word_count < RANDOM_WORDS) begin
            in_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            out_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            case ($urandom_range(0, 7))
                0, 1, 2: len = $urandom_range(0, 8);
                3, 4:    len = $urandom_range(53, 57);
                5:       len = $urandom_range(61, 65);
                default: len = $urandom_range(9, 30);
            endcase
            send_message(len, word_count);
            // hold off once until every digest is back
            if (!paused && word_count > RANDOM_WORDS / 2) begin
                drain_digests();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        restart_chain();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_message();
        test_idle_and_extremes();
        test_abc();
        drain_digests();
        test_random_messages();

        drain_digests();
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0 && expected_digest.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hdl/sha1he_pkg.sv
hdl/sha1he_front.sv
hdl/sha1he_back.sv
hdl/sha1_hash_engine.sv
tb/testbench.sv
